// ----- design/masked_window_variance_macros.svh -----
// Assertion helpers used by the design file masked_window_variance.sv.
`ifndef MASKED_WINDOW_VARIANCE_MACROS_SVH
`define MASKED_WINDOW_VARIANCE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MWV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mwv check failed");

// Next-cycle implication, checked outside reset.
`define MWV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mwv check failed");

`endif

// ----- design/mwv_pkg.sv -----
package mwv_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL,
      ST_SUB,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef logic [1:0] csr_addr_type;

   localparam csr_addr_type CSR_IMAGE_COLS  = 2'd0;
   localparam csr_addr_type CSR_IMAGE_ROWS  = 2'd1;
   localparam csr_addr_type CSR_WINDOW_SIZE = 2'd2;
   localparam csr_addr_type CSR_IGNORE_MASK = 2'd3;

   localparam int CSR_DATA_W  = 13;
   localparam int COLS_REG_W  = 11;
   localparam int ROWS_REG_W  = 13;
   localparam int KSIZE_W     = 4;
   localparam int FLAG_W      = 8;
   localparam int ROW_W       = 13;
   localparam int MAX_ROWS    = 4096;
   localparam int CROW_W      = 12;
   localparam int VAR_W       = 31;
   localparam int COUNT_OUT_W = 8;
   localparam int HALF_W      = 3;
   localparam int MIN_WINDOW  = 3;

   localparam logic [VAR_W-1:0]       VAR_MAX   = '1;
   localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = '1;

endpackage

// ----- design/masked_window_variance.sv -----
// Masked sliding-window variance. Samples (signed Q3.12) and flag bytes arrive in raster
// order over an extended raster of (rows + k/2) by (cols + k/2) positions; padding items
// still have to be sent. Once the window around an image pixel is complete, one item
// comes out with the pixel position, the variance (n*sumsq - sum^2)/n^2 in unsigned Q7.24,
// truncated and saturated, and the number n of samples counted. The newest MAX_WINDOW
// image rows sit in one line memory (no clearing after reset). An item that produces no
// result is taken in the idle state. An item that produces a result starts a sweep of
// the W window samples after clipping (up to 225), read one per cycle from the single
// read port of the line memory, then the drain, multiply and subtract states, then the
// NUM_W (48 at the default parameters) steps of the bit-serial divider; when no sample
// in the window counts, the divider is skipped. A finished result waits in the output
// register while the next item is taken. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
`include "masked_window_variance_macros.svh"

module masked_window_variance import mwv_pkg::*; #(
   parameter int MAX_COLS    = 1024,
   parameter int MAX_WINDOW  = 15,
   parameter int SAMPLE_BITS = 16,
   localparam int CI_W  = $clog2(MAX_COLS),
   localparam int IN_W  = ((SAMPLE_BITS + FLAG_W + 7) / 8) * 8,
   localparam int OUT_W = ((CROW_W + CI_W + VAR_W + COUNT_OUT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata, lowest bit up: sample_value, pixel_flags, zero fill.
   input  logic [IN_W-1:0]       req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata, lowest bit up: center_row, center_col, window_variance, sample_count,
   // zero fill.
   output logic [OUT_W-1:0]      rsp_tdata,
   // rsp_tlast carries last_of_frame.
   output logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  csr_addr_type          csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RC_W     = $clog2(MAX_COLS + MAX_WINDOW);
   localparam int SLOT_W   = $clog2(MAX_WINDOW);
   localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
   localparam int CNT_W    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int SUM_W    = SAMPLE_BITS + CNT_W;
   localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W;
   localparam int NUM_W    = SQ_W + CNT_W;
   localparam int DEN_W    = 2 * CNT_W;
   localparam int STEP_W   = $clog2(NUM_W);
   localparam int ENTRY_W  = SAMPLE_BITS + 1;
   localparam int PAD_W    = OUT_W - (CROW_W + CI_W + VAR_W + COUNT_OUT_W);

   // Configuration registers.
   logic [COLS_REG_W-1:0] cfg_cols_ff;
   logic [ROWS_REG_W-1:0] cfg_rows_ff;
   logic [KSIZE_W-1:0]    cfg_ksize_ff;
   logic [FLAG_W-1:0]     cfg_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff  <= COLS_REG_W'(1024);
         cfg_rows_ff  <= ROWS_REG_W'(1024);
         cfg_ksize_ff <= KSIZE_W'(3);
         cfg_mask_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_IMAGE_COLS:  cfg_cols_ff  <= csr_wdata[COLS_REG_W-1:0];
            CSR_IMAGE_ROWS:  cfg_rows_ff  <= csr_wdata[ROWS_REG_W-1:0];
            CSR_WINDOW_SIZE: cfg_ksize_ff <= csr_wdata[KSIZE_W-1:0];
            CSR_IGNORE_MASK: cfg_mask_ff  <= csr_wdata[FLAG_W-1:0];
            default:         cfg_mask_ff  <= cfg_mask_ff;
         endcase
      end
   end

   // Effective sizes after clamping. An even window acts as the next odd one, which
   // gives the same half size.
   logic [RC_W-1:0]   cols_eff;
   logic [ROW_W-1:0]  rows_eff;
   logic [HALF_W-1:0] half_eff;
   logic [KSIZE_W-1:0] ksize_eff;

   always_comb begin
      if (cfg_cols_ff == '0) begin
         cols_eff = RC_W'(1);
      end else if (32'(cfg_cols_ff) > MAX_COLS) begin
         cols_eff = RC_W'(MAX_COLS);
      end else begin
         cols_eff = RC_W'(cfg_cols_ff);
      end
      if (cfg_rows_ff == '0) begin
         rows_eff = ROW_W'(1);
      end else if (32'(cfg_rows_ff) > MAX_ROWS) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = cfg_rows_ff;
      end
      ksize_eff = (32'(cfg_ksize_ff) < MIN_WINDOW) ? KSIZE_W'(MIN_WINDOW) : cfg_ksize_ff;
      if (32'(ksize_eff >> 1) > HALF_MAX) begin
         half_eff = HALF_W'(HALF_MAX);
      end else begin
         half_eff = HALF_W'(ksize_eff >> 1);
      end
   end

   // Raster position and the line-memory row that raster row maps to.
   logic [ROW_W-1:0]  raster_row_ff, raster_row_in;
   logic [RC_W-1:0]   raster_col_ff, raster_col_in;
   logic [SLOT_W-1:0] raster_slot_ff, raster_slot_in;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   logic signed [SAMPLE_BITS-1:0] in_sample;
   logic [FLAG_W-1:0]             in_flags;

   assign in_sample = req_tdata[SAMPLE_BITS-1:0];
   assign in_flags  = req_tdata[SAMPLE_BITS +: FLAG_W];

   // Window geometry for the item at the current raster position.
   logic [ROW_W-1:0] hr, cr, r0, r1, dr;
   logic [RC_W-1:0]  hc, cc, c0, c1;
   logic             in_image, due;
   logic [SLOT_W-1:0] slot_start;
   logic              row_step;
   logic [RC_W:0]     col_next;

   always_comb begin
      hr = ROW_W'(half_eff);
      hc = RC_W'(half_eff);
      in_image = (raster_row_ff < rows_eff) && (raster_col_ff < cols_eff);
      cr = raster_row_ff - hr;
      cc = raster_col_ff - hc;
      due = (raster_row_ff >= hr) && (raster_col_ff >= hc) && (cr < rows_eff) &&
            (cc < cols_eff);
      r0 = (cr >= hr) ? cr - hr : '0;
      r1 = (raster_row_ff > rows_eff - ROW_W'(1)) ? rows_eff - ROW_W'(1) : raster_row_ff;
      dr = raster_row_ff - r0;
      c0 = (cc >= hc) ? cc - hc : '0;
      c1 = (raster_col_ff > cols_eff - RC_W'(1)) ? cols_eff - RC_W'(1) : raster_col_ff;
      // The window spans fewer rows than the memory holds, so one wrap is enough.
      if (32'(raster_slot_ff) >= 32'(dr)) begin
         slot_start = SLOT_W'(32'(raster_slot_ff) - 32'(dr));
      end else begin
         slot_start = SLOT_W'(32'(raster_slot_ff) + MAX_WINDOW - 32'(dr));
      end

      // Raster advance; counters beyond new bounds wrap on their next step.
      col_next = {1'b0, raster_col_ff} + (RC_W + 1)'(1);
      row_step = col_next >= ({1'b0, cols_eff} + (RC_W + 1)'(half_eff));
      raster_col_in = row_step ? '0 : col_next[RC_W-1:0];
      raster_row_in = row_step ? raster_row_ff + ROW_W'(1) : raster_row_ff;
      if ({1'b0, raster_row_in} >= ({1'b0, rows_eff} + (ROW_W + 1)'(half_eff))) begin
         raster_row_in = '0;
      end
      if (raster_row_in == '0) begin
         raster_slot_in = '0;
      end else if (row_step) begin
         raster_slot_in = (32'(raster_slot_ff) == MAX_WINDOW - 1) ? '0 :
                          raster_slot_ff + SLOT_W'(1);
      end else begin
         raster_slot_in = raster_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raster_row_ff  <= '0;
         raster_col_ff  <= '0;
         raster_slot_ff <= '0;
      end else if (accept) begin
         raster_row_ff  <= raster_row_in;
         raster_col_ff  <= raster_col_in;
         raster_slot_ff <= raster_slot_in;
      end
   end

   // Line memory: one row per image row, the newest MAX_WINDOW rows kept. Each entry is
   // a sample and a bit that says whether it counts; the mask is applied on write.
   logic [ENTRY_W-1:0] line_mem [MAX_WINDOW][MAX_COLS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               rd_en;
   logic [SLOT_W-1:0]  scan_slot_ff;
   logic [CI_W-1:0]    scan_col_ff;

   always_ff @(posedge clock) begin
      if (accept && in_image) begin
         line_mem[raster_slot_ff][raster_col_ff[CI_W-1:0]] <=
            {((in_flags & cfg_mask_ff) == '0), in_sample};
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[scan_slot_ff][scan_col_ff];
      end
   end

   // Scan control: columns run from col_lo to col_hi, then the next row.
   logic [CI_W-1:0]   col_lo_ff, col_hi_ff;
   logic [SLOT_W-1:0] rows_left_ff;
   logic              scan_last;

   assign scan_last = (scan_col_ff == col_hi_ff) && (rows_left_ff == '0);

   // Result being built.
   logic [CROW_W-1:0] res_row_ff;
   logic [CI_W-1:0]   res_col_ff;
   logic              res_last_ff;

   // Accumulators and arithmetic.
   logic signed [SUM_W-1:0]       sum_ff;
   logic [SQ_W-1:0]               sumsq_ff;
   logic [CNT_W-1:0]              n_ff;
   logic signed [SAMPLE_BITS-1:0] rd_sample;
   logic                          rd_counted;
   logic [2*SAMPLE_BITS-1:0]      rd_square;
   logic [SUM_W-1:0]              sum_mag;
   logic [NUM_W-1:0]              prod_a_ff;
   logic [2*SUM_W-1:0]            prod_b_ff;
   logic [DEN_W-1:0]              den_ff;
   logic [NUM_W-1:0]              div_q_ff;
   logic [DEN_W-1:0]              div_rem_ff;
   logic [STEP_W-1:0]             div_step_ff;
   logic [DEN_W:0]                trial;
   logic                          trial_ge;

   assign rd_sample  = rd_data_ff[SAMPLE_BITS-1:0];
   assign rd_counted = rd_data_ff[SAMPLE_BITS];
   assign rd_square  = (2*SAMPLE_BITS)'(rd_sample * rd_sample);
   assign sum_mag    = (sum_ff < 0) ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial      = {div_rem_ff, div_q_ff[NUM_W-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};

   // Output register.
   logic             rsp_tvalid_ff;
   logic [OUT_W-1:0] rsp_tdata_ff;
   logic             rsp_tlast_ff;
   logic             out_load;
   logic [NUM_W+VAR_W-1:0]       quo_ext;
   logic [CNT_W+COUNT_OUT_W-1:0] n_ext;
   logic [VAR_W-1:0]             var_out;
   logic [COUNT_OUT_W-1:0]       count_out;

   always_comb begin
      quo_ext   = (NUM_W + VAR_W)'(div_q_ff);
      n_ext     = (CNT_W + COUNT_OUT_W)'(n_ff);
      var_out   = (quo_ext > (NUM_W + VAR_W)'(VAR_MAX)) ? VAR_MAX : quo_ext[VAR_W-1:0];
      count_out = (n_ext > (CNT_W + COUNT_OUT_W)'(COUNT_MAX)) ? COUNT_MAX :
                  n_ext[COUNT_OUT_W-1:0];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rd_en      = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && due) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUB;
         ST_SUB:   state_in = (n_ff == '0) ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if (div_step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept && due) begin
         scan_slot_ff <= slot_start;
         scan_col_ff  <= c0[CI_W-1:0];
         col_lo_ff    <= c0[CI_W-1:0];
         col_hi_ff    <= c1[CI_W-1:0];
         rows_left_ff <= SLOT_W'(r1 - r0);
         res_row_ff   <= cr[CROW_W-1:0];
         res_col_ff   <= cc[CI_W-1:0];
         res_last_ff  <= (cr == rows_eff - ROW_W'(1)) && (cc == cols_eff - RC_W'(1));
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         n_ff         <= '0;
      end else begin
         if (rd_en) begin
            if (scan_col_ff == col_hi_ff) begin
               scan_col_ff  <= col_lo_ff;
               rows_left_ff <= rows_left_ff - SLOT_W'(1);
               scan_slot_ff <= (32'(scan_slot_ff) == MAX_WINDOW - 1) ? '0 :
                               scan_slot_ff + SLOT_W'(1);
            end else begin
               scan_col_ff <= scan_col_ff + CI_W'(1);
            end
         end
         if (rd_vld_ff && rd_counted) begin
            sum_ff   <= sum_ff + SUM_W'(rd_sample);
            sumsq_ff <= sumsq_ff + SQ_W'(rd_square);
            n_ff     <= n_ff + CNT_W'(1);
         end
      end

      if (state_ff == ST_MUL) begin
         prod_a_ff <= sumsq_ff * NUM_W'(n_ff);
         prod_b_ff <= (2*SUM_W)'(sum_mag) * (2*SUM_W)'(sum_mag);
         den_ff    <= DEN_W'(n_ff) * DEN_W'(n_ff);
      end

      // Restoring division, one quotient bit per cycle; the numerator shifts out
      // at the top while quotient bits shift in at the bottom.
      if (state_ff == ST_SUB) begin
         div_q_ff    <= (n_ff == '0) ? '0 : prod_a_ff - NUM_W'(prod_b_ff);
         div_rem_ff  <= '0;
         div_step_ff <= STEP_W'(NUM_W - 1);
      end else if (state_ff == ST_DIV) begin
         div_rem_ff  <= trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         div_q_ff    <= {div_q_ff[NUM_W-2:0], trial_ge};
         div_step_ff <= div_step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= {{PAD_W{1'b0}}, count_out, var_out, res_col_ff, res_row_ff};
         rsp_tlast_ff <= res_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Read data only returns while the window is being swept.
   `MWV_ASSERT_NOW(a_read_in_scan, clock, reset, rd_vld_ff,
      (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))
   // The divider never runs with an empty window.
   `MWV_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == ST_DIV, n_ff != '0)
   // A finished result always lands in the output register.
   `MWV_ASSERT_NEXT(a_done_loads, clock, reset, out_load, rsp_tvalid_ff && state_ff == ST_IDLE)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import mwv_pkg::*;

   // Field layout of the result item, lowest bit first.
   localparam int COL_LO   = CROW_W;
   localparam int VAR_LO   = COL_LO + 10;
   localparam int CNT_LO   = VAR_LO + VAR_W;
   localparam int MAX_LINES = 15;
   localparam int LINE_COLS = 1024;
   // Margin that wait_idle adds after the last expected result.
   localparam int DRAIN_CYCLES = 300;
   localparam longint CYCLE_LIMIT = 6000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata, lowest bit up: sample_value, pixel_flags.
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata, lowest bit up: center_row, center_col, window_variance, sample_count, fill.
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wen = 1'b0;
   csr_addr_type csr_addr = CSR_IMAGE_COLS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   masked_window_variance DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      logic [CROW_W-1:0]      row;
      logic [9:0]             col;
      logic [VAR_W-1:0]       variance;
      logic [COUNT_OUT_W-1:0] count;
      logic                   last;
   } pixel_result_type;

   // Expected pixel results, oldest first.
   pixel_result_type pending_pixels[$];

   // Our own copy of the block's configuration and scan state.
   logic [10:0] cfg_cols = 11'd1024;
   logic [12:0] cfg_rows = 13'd1024;
   logic [3:0]  cfg_ksize = 4'd3;
   logic [7:0]  cfg_mask = 8'd0;
   int unsigned scan_row = 0;
   int unsigned scan_col = 0;
   logic signed [15:0] line_value[MAX_LINES][LINE_COLS];
   bit                 line_counted[MAX_LINES][LINE_COLS];

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  frames_sent = 0;
   int  mismatches = 0;
   longint cycles = 0;

   function automatic int unsigned used_cols();
      if (cfg_cols < 1) return 1;
      if (cfg_cols > 1024) return 1024;
      return cfg_cols;
   endfunction

   function automatic int unsigned used_rows();
      if (cfg_rows < 1) return 1;
      if (cfg_rows > 4096) return 4096;
      return cfg_rows;
   endfunction

   function automatic int unsigned used_half();
      int unsigned k;
      k = (cfg_ksize < 3) ? 3 : cfg_ksize;
      return (k / 2 > 7) ? 7 : k / 2;
   endfunction

   // Advances the scan by one accepted item and queues the pixel result it completes.
   function automatic void predict_pixel(logic [15:0] sample, logic [7:0] flags);
      int unsigned cols, rows, h, cr, cc, r0, r1, c0, c1, n;
      longint sum;
      longint unsigned sumsq, mag;
      logic [127:0] spread, quotient;
      pixel_result_type res;
      cols = used_cols();
      rows = used_rows();
      h = used_half();
      if (scan_row < rows && scan_col < cols) begin
         line_value[scan_row % MAX_LINES][scan_col] = sample;
         line_counted[scan_row % MAX_LINES][scan_col] = ((flags & cfg_mask) == 0);
      end
      if (scan_row >= h && scan_col >= h && scan_row - h < rows && scan_col - h < cols) begin
         cr = scan_row - h;
         cc = scan_col - h;
         r0 = (cr >= h) ? cr - h : 0;
         c0 = (cc >= h) ? cc - h : 0;
         r1 = (cr + h > rows - 1) ? rows - 1 : cr + h;
         c1 = (cc + h > cols - 1) ? cols - 1 : cc + h;
         n = 0;
         sum = 0;
         sumsq = 0;
         for (int unsigned rr = r0; rr <= r1; rr++) begin
            for (int unsigned cx = c0; cx <= c1; cx++) begin
               if (line_counted[rr % MAX_LINES][cx]) begin
                  sum += line_value[rr % MAX_LINES][cx];
                  sumsq += longint'(line_value[rr % MAX_LINES][cx]) *
                           longint'(line_value[rr % MAX_LINES][cx]);
                  n++;
               end
            end
         end
         res.variance = '0;
         if (n > 0) begin
            mag = (sum < 0) ? -sum : sum;
            spread = 128'(sumsq) * 128'(n) - 128'(mag) * 128'(mag);
            quotient = spread / (128'(n) * 128'(n));
            res.variance = (quotient > 128'(VAR_MAX)) ? VAR_MAX : quotient[VAR_W-1:0];
         end
         res.row = cr[CROW_W-1:0];
         res.col = cc[9:0];
         res.count = (n > 255) ? COUNT_MAX : n[7:0];
         res.last = (cr == rows - 1 && cc == cols - 1);
         pending_pixels.push_back(res);
      end
      scan_col++;
      if (scan_col >= cols + h) begin
         scan_col = 0;
         scan_row++;
      end
      if (scan_row >= rows + h) scan_row = 0;
   endfunction

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      pixel_result_type want;
      pixel_result_type got;
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, pending_pixels.size());
         $display("Simulation FAILED");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[CROW_W-1:0];
         got.col = rsp_tdata[COL_LO +: 10];
         got.variance = rsp_tdata[VAR_LO +: VAR_W];
         got.count = rsp_tdata[CNT_LO +: COUNT_OUT_W];
         got.last = rsp_tlast;
         results_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: row %0d col %0d var %0d n %0d last %0d",
                        got.row, got.col, got.variance, got.count, got.last);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected row %0d col %0d var %0d n %0d last %0d,",
                            " got row %0d col %0d var %0d n %0d last %0d"},
                           want.row, want.col, want.variance, want.count, want.last,
                           got.row, got.col, got.variance, got.count, got.last);
            end
         end
      end
   end

   // Sends one item, idling first when the phase asks for it. Valid stays high
   // after acceptance until the next idle phase or wait_idle drops it.
   task automatic send_item(logic [15:0] sample, logic [7:0] flags);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {flags, sample};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_pixel(sample, flags);
   endtask

   // Stops the sender and waits until the block has delivered everything.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_addr_type addr, logic [CSR_DATA_W-1:0] value);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (addr)
         CSR_IMAGE_COLS:  cfg_cols = value[10:0];
         CSR_IMAGE_ROWS:  cfg_rows = value[12:0];
         CSR_WINDOW_SIZE: cfg_ksize = value[3:0];
         default:         cfg_mask = value[7:0];
      endcase
   endtask

   task automatic configure(int cols, int rows, int ksize, int mask);
      write_csr(CSR_IMAGE_COLS, CSR_DATA_W'(cols));
      write_csr(CSR_IMAGE_ROWS, CSR_DATA_W'(rows));
      write_csr(CSR_WINDOW_SIZE, CSR_DATA_W'(ksize));
      write_csr(CSR_IGNORE_MASK, CSR_DATA_W'(mask));
   endtask

   // Samples lean toward the extremes so that saturation paths get exercised.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_flags();
      return ($urandom_range(9) < 6) ? 8'h00 : 8'($urandom);
   endfunction

   // One complete extended raster, so that every window only reads entries
   // written during this frame.
   task automatic send_frame();
      int unsigned total;
      total = (used_rows() + used_half()) * (used_cols() + used_half());
      for (int unsigned i = 0; i < total; i++) send_item(pick_sample(), pick_flags());
      frames_sent++;
   endtask

   // Extreme samples and flags on a small image, masked and unmasked.
   task automatic test_directed();
      logic [15:0] values[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000};
      configure(4, 3, 3, 0);
      for (int i = 0; i < 20; i++)
         send_item(values[i % 5], (i % 3 == 0) ? 8'hFF : 8'h00);
      wait_idle();
      write_csr(CSR_IGNORE_MASK, CSR_DATA_W'(8'h81));
      for (int i = 0; i < 20; i++)
         send_item(values[(i + 2) % 5], (i % 2 == 0) ? 8'h80 : 8'h7E);
      wait_idle();
   endtask

   // Zero sizes, odd window settings and a window larger than the image.
   task automatic test_size_limits();
      int ksizes[6] = '{0, 1, 2, 4, 14, 15};
      configure(0, 0, 3, 0);
      send_frame();
      wait_idle();
      foreach (ksizes[i]) begin
         configure(5 + i, 4, ksizes[i], (i == 5) ? 8'h01 : 8'h00);
         send_frame();
         wait_idle();
      end
      configure(9, 8, 15, 0);
      send_frame();
      wait_idle();
   endtask

   // Random small frames under one idling and stalling pattern, until item_goal items are sent.
   task automatic test_random_frames(int idle_pct, int stall_pct, int item_goal);
      int first;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      first = items_sent;
      while (items_sent - first < item_goal) begin
         configure($urandom_range(12, 1), $urandom_range(10, 1), $urandom_range(15),
                   ($urandom_range(2) == 0) ? 0 : $urandom_range(255));
         send_frame();
         wait_idle();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_size_limits();
      test_random_frames(0, 0, 60);
      test_random_frames(60, 0, 60);
      test_random_frames(0, 60, 60);
      test_random_frames(7, 7, 60);
      configure(3, 3, 15, 0);
      send_frame();
      wait_idle();
      $display("Sent %0d items in %0d frames and checked %0d pixel results.",
               items_sent, frames_sent, results_seen);
      $display("Mismatches: %0d; runs used idle and stall phases, masks and clamped sizes.",
               mismatches);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
